// ===== hw/rtl/ising_metropolis_lattice_top_defines.svh =====
// Assertion macros for the lattice top-level RTL.
// Every macro expects clk and rst_n to be visible where it is used.
`ifndef ISING_METROPOLIS_LATTICE_TOP_DEFINES_SVH
`define ISING_METROPOLIS_LATTICE_TOP_DEFINES_SVH

// Condition must hold on every clock edge outside reset.
`define IML_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold on the same edge as the antecedent.
`define IML_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold on the edge after the antecedent.
`define IML_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/iml_pkg.sv =====
// Shared constants, types and index helpers for the Ising lattice block.
// Used by iml_flip_eval and ising_metropolis_lattice_top; no dependencies.
package iml_pkg;

    localparam int LATTICE_ROWS = 128;
    localparam int LATTICE_COLS = 128;
    localparam int ROW_W        = $clog2(LATTICE_ROWS);
    localparam int COL_W        = $clog2(LATTICE_COLS);
    localparam int SITE_COUNT   = LATTICE_ROWS * LATTICE_COLS;

    localparam int REQ_W       = 2;
    localparam int ADDR_IN_W   = 7;
    localparam int FRAC_W      = 32;
    localparam int DELTA_W     = 5;
    localparam int ENERGY_W    = 17;
    localparam int MAG_W       = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * SITE_COUNT);
    localparam logic [MAG_W-1:0]    MAG_RESET    = MAG_W'(SITE_COUNT);
    localparam logic [FRAC_W-1:0]   THR_DE4_RESET = 32'd1929853361;
    localparam logic [FRAC_W-1:0]   THR_DE8_RESET = 32'd867141012;

    // dE = 4 * (neighbours agreeing with the site) - 8
    localparam logic [DELTA_W-1:0] DE_OFFSET = DELTA_W'(8);
    localparam logic [MAG_W-1:0]   MAG_UP    = MAG_W'(2);
    localparam logic [MAG_W-1:0]   MAG_DOWN  = MAG_W'(-2);

    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TRIAL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_DE4 = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DE8 = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CENTRE,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic               flip;
        logic               accepted;
        logic               spin_after;
        logic [DELTA_W-1:0] delta;
    } eval_t;

    // Fold an incoming row number onto the lattice (constant-multiple compares).
    function automatic logic [ROW_W-1:0] wrap_row(input logic [ADDR_IN_W-1:0] v);
        logic [ADDR_IN_W-1:0] rem;
        rem = v;
        for (int q = 1; q * LATTICE_ROWS < (1 << ADDR_IN_W); q++) begin
            if (v >= ADDR_IN_W'(q * LATTICE_ROWS)) begin
                rem = v - ADDR_IN_W'(q * LATTICE_ROWS);
            end
        end
        return ROW_W'(rem);
    endfunction

    function automatic logic [COL_W-1:0] wrap_col(input logic [ADDR_IN_W-1:0] v);
        logic [ADDR_IN_W-1:0] rem;
        rem = v;
        for (int q = 1; q * LATTICE_COLS < (1 << ADDR_IN_W); q++) begin
            if (v >= ADDR_IN_W'(q * LATTICE_COLS)) begin
                rem = v - ADDR_IN_W'(q * LATTICE_COLS);
            end
        end
        return COL_W'(rem);
    endfunction

    function automatic logic [ROW_W-1:0] row_up(input logic [ROW_W-1:0] r);
        return (r == '0) ? ROW_W'(LATTICE_ROWS - 1) : r - 1'b1;
    endfunction

    function automatic logic [ROW_W-1:0] row_down(input logic [ROW_W-1:0] r);
        return (r == ROW_W'(LATTICE_ROWS - 1)) ? '0 : r + 1'b1;
    endfunction

    function automatic logic [COL_W-1:0] col_left(input logic [COL_W-1:0] c);
        return (c == '0) ? COL_W'(LATTICE_COLS - 1) : c - 1'b1;
    endfunction

    function automatic logic [COL_W-1:0] col_right(input logic [COL_W-1:0] c);
        return (c == COL_W'(LATTICE_COLS - 1)) ? '0 : c + 1'b1;
    endfunction

endpackage

// ===== hw/rtl/ising_metropolis_lattice_top.sv =====
// Top level of the Ising lattice: request sequencer, totals and row memory.
// Depends on iml_pkg, iml_spin_ram and iml_flip_eval.
//
//  channel   handshake                     payload
//  request   start, busy                   req_type, row, col, spin_in, random_fraction
//  result    done (one-cycle strobe)       accepted, spin_out, delta_energy,
//                                          total_energy, total_magnetization
//  config    cfg_write                     cfg_index, cfg_data
//
// A request runs in steps: rows above and below are read on the two RAM read
// ports, then the centre row, then the flip is evaluated and the row written back.
// done rises on the write-back edge and lasts one cycle; the next request can be
// taken at the edge that ends it. After reset the RAM is filled with +1 spins, one
// row per cycle, for all LATTICE_ROWS (128) rows with busy high. No result stalls.
`include "ising_metropolis_lattice_top_defines.svh"

module ising_metropolis_lattice_top
    import iml_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [REQ_W-1:0]           req_type,
    input  logic [ADDR_IN_W-1:0]       row,
    input  logic [ADDR_IN_W-1:0]       col,
    input  logic                       spin_in,
    input  logic [FRAC_W-1:0]          random_fraction,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output logic                       done,
    output logic                       accepted,
    output logic                       spin_out,
    output logic signed [DELTA_W-1:0]  delta_energy,
    output logic signed [ENERGY_W-1:0] total_energy,
    output logic signed [MAG_W-1:0]    total_magnetization
);

    state_t                  state_reg, state_next;
    logic [ROW_W-1:0]        clear_cnt_reg, clear_cnt_next;

    logic [REQ_W-1:0]        req_type_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [COL_W-1:0]        col_reg;
    logic                    spin_in_reg;
    logic [FRAC_W-1:0]       frac_reg;
    logic                    up_bit_reg;
    logic                    dn_bit_reg;

    logic [FRAC_W-1:0]       thr_de4_reg;
    logic [FRAC_W-1:0]       thr_de8_reg;
    logic [ENERGY_W-1:0]     energy_reg, energy_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;

    logic                    done_reg;
    logic                    accepted_reg;
    logic                    spin_out_reg;
    logic [DELTA_W-1:0]      delta_reg;

    logic [ROW_W-1:0]        row_wrapped;
    logic [COL_W-1:0]        col_wrapped;
    logic                    load_req;
    logic                    capture_nb;
    logic                    commit;

    logic                    ram_we;
    logic [ROW_W-1:0]        ram_waddr;
    logic [LATTICE_COLS-1:0] ram_wdata;
    logic [ROW_W-1:0]        ram_raddr_a;
    logic [ROW_W-1:0]        ram_raddr_b;
    logic [LATTICE_COLS-1:0] ram_rdata_a;
    logic [LATTICE_COLS-1:0] ram_rdata_b;

    eval_t                   eval;
    logic [LATTICE_COLS-1:0] eval_row;

    iml_spin_ram #(
        .DEPTH (LATTICE_ROWS),
        .WIDTH (LATTICE_COLS)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    iml_flip_eval u_eval (
        .centre_row (ram_rdata_a),
        .up_bit     (up_bit_reg),
        .dn_bit     (dn_bit_reg),
        .col        (col_reg),
        .req_type   (req_type_reg),
        .spin_in    (spin_in_reg),
        .frac       (frac_reg),
        .thr_de4    (thr_de4_reg),
        .thr_de8    (thr_de8_reg),
        .result     (eval),
        .new_row    (eval_row)
    );

    assign row_wrapped = wrap_row(row);
    assign col_wrapped = wrap_col(col);

    always_comb
    begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        busy           = 1'b1;
        load_req       = 1'b0;
        capture_nb     = 1'b0;
        commit         = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = row_reg;
        ram_wdata      = eval_row;
        ram_raddr_a    = row_reg;
        ram_raddr_b    = row_down(row_wrapped);

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clear_cnt_reg;
                ram_wdata = '1;
                if (clear_cnt_reg == ROW_W'(LATTICE_ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clear_cnt_next = clear_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                busy        = 1'b0;
                ram_raddr_a = row_up(row_wrapped);
                if (start)
                begin
                    load_req   = 1'b1;
                    state_next = ST_CENTRE;
                end
            end
            ST_CENTRE:
            begin
                // neighbour rows arrive now; fetch the site's own row
                capture_nb = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                commit     = 1'b1;
                ram_we     = eval.flip;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        energy_next = energy_reg;
        mag_next    = mag_reg;
        if (commit && eval.flip)
        begin
            energy_next = energy_reg
                        + {{(ENERGY_W - DELTA_W){eval.delta[DELTA_W-1]}}, eval.delta};
            mag_next    = mag_reg + (eval.spin_after ? MAG_UP : MAG_DOWN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
            thr_de4_reg   <= THR_DE4_RESET;
            thr_de8_reg   <= THR_DE8_RESET;
            energy_reg    <= ENERGY_RESET;
            mag_reg       <= MAG_RESET;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            energy_reg    <= energy_next;
            mag_reg       <= mag_next;
            done_reg      <= commit;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_DE4: thr_de4_reg <= cfg_data;
                    CFG_DE8: thr_de8_reg <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_req)
        begin
            req_type_reg <= req_type;
            row_reg      <= row_wrapped;
            col_reg      <= col_wrapped;
            spin_in_reg  <= spin_in;
            frac_reg     <= random_fraction;
        end
        if (capture_nb)
        begin
            up_bit_reg <= ram_rdata_a[col_reg];
            dn_bit_reg <= ram_rdata_b[col_reg];
        end
        if (commit)
        begin
            accepted_reg <= eval.accepted;
            spin_out_reg <= eval.spin_after;
            delta_reg    <= eval.delta;
        end
    end

    assign done                = done_reg;
    assign accepted            = accepted_reg;
    assign spin_out            = spin_out_reg;
    assign delta_energy        = signed'(delta_reg);
    assign total_energy        = signed'(energy_reg);
    assign total_magnetization = signed'(mag_reg);

    `IML_ASSERT_SAME(a_done_after_eval, done_reg,
        $past(state_reg) == ST_EVAL, "result without evaluation")
    `IML_ASSERT_HOLDS(a_ram_write_owner,
        !ram_we || state_reg == ST_CLEAR || state_reg == ST_EVAL, "stray RAM write")
    `IML_ASSERT_NEXT(a_request_advances, start && !busy,
        state_reg == ST_CENTRE, "request not taken up")
    `IML_ASSERT_SAME(a_flip_moves_mag, done_reg && accepted_reg,
        total_magnetization != $past(total_magnetization),
        "kept flip left magnetization unchanged")

endmodule

// ===== hw/rtl/iml_spin_ram.sv =====
// Generic synchronous RAM: one write port, two registered read ports.
// Holds one lattice row per word; no package dependency.
module iml_spin_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 128,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== hw/rtl/iml_flip_eval.sv =====
// Flip evaluation: energy change, Metropolis acceptance or forced write, and row update.
// Depends on iml_pkg for widths, request codes and eval_t.
module iml_flip_eval
    import iml_pkg::*;
(
    input  logic [LATTICE_COLS-1:0] centre_row,
    input  logic                    up_bit,
    input  logic                    dn_bit,
    input  logic [COL_W-1:0]        col,
    input  logic [REQ_W-1:0]        req_type,
    input  logic                    spin_in,
    input  logic [FRAC_W-1:0]       frac,
    input  logic [FRAC_W-1:0]       thr_de4,
    input  logic [FRAC_W-1:0]       thr_de8,
    output eval_t                   result,
    output logic [LATTICE_COLS-1:0] new_row
);

    logic               site;
    logic               lf_bit;
    logic               rt_bit;
    logic [3:0]         agree;
    logic [2:0]         agree_cnt;
    logic [DELTA_W-1:0] de;
    logic               keep;

    always_comb
    begin
        site      = centre_row[col];
        lf_bit    = centre_row[col_left(col)];
        rt_bit    = centre_row[col_right(col)];
        agree     = ~({up_bit, dn_bit, lf_bit, rt_bit} ^ {4{site}});
        agree_cnt = 3'($countones(agree));
        de        = DELTA_W'({agree_cnt, 2'b00}) - DE_OFFSET;

        // three agreeing neighbours cost +4, four cost +8
        case (agree_cnt)
            3'd3:    keep = (frac <= thr_de4);
            3'd4:    keep = (frac <= thr_de8);
            default: keep = 1'b1;
        endcase

        result = '0;
        unique case (req_type)
            REQ_WRITE:
            begin
                if (site != spin_in)
                begin
                    result.flip  = 1'b1;
                    result.delta = de;
                end
            end
            REQ_TRIAL:
            begin
                result.delta = de;
                if (keep)
                begin
                    result.flip     = 1'b1;
                    result.accepted = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        result.spin_after = site ^ result.flip;

        new_row      = centre_row;
        new_row[col] = result.spin_after;
    end

endmodule
